>>> hw/rtl/clocked_panel_bus_transceiver_macros.svh
// Assertion macros for the clocked panel bus transceiver.
`ifndef CLOCKED_PANEL_BUS_TRANSCEIVER_MACROS_SVH
`define CLOCKED_PANEL_BUS_TRANSCEIVER_MACROS_SVH

`ifndef ASSERT_OFF

// property must hold at every clock edge out of reset
`define CPBT_ASSERT(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// condition must never be true out of reset
`define CPBT_NEVER(label, clk, rst_n, cond, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);

`else

`define CPBT_ASSERT(label, clk, rst_n, prop, msg)
`define CPBT_NEVER(label, clk, rst_n, cond, msg)

`endif

`endif

>>> hw/rtl/cpbt_pkg.sv
// Shared constants for the clocked panel bus transceiver.
`default_nettype none

package cpbt_pkg;

    localparam int WORD_BITS_DEF = 64;

    localparam int DATA_W   = 64;
    localparam int COUNT_W  = 7;
    localparam int GAP_W    = 16;
    localparam int TICK_W   = 8;
    localparam int CFG_IDX_W = 2;
    localparam int CFG_DATA_W = 16;

    localparam int S_TDATA_W = 72;
    localparam int M_TDATA_W = 80;

    localparam logic [GAP_W-1:0]  GAP_TICKS_RST    = 16'd250;
    localparam logic [TICK_W-1:0] HOLD_TICKS_RST   = 8'd52;
    localparam logic [TICK_W-1:0] SAMPLE_TICKS_RST = 8'd12;
    localparam logic [GAP_W-1:0]  GAP_MAX          = 16'hFFFF;

    localparam logic [CFG_IDX_W-1:0] CFG_GAP_TICKS    = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_HOLD_TICKS   = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_SAMPLE_TICKS = 2'd2;

    localparam logic [1:0] PHASE_IDLE = 2'd0;
    localparam logic [1:0] PHASE_HOLD = 2'd1;
    localparam logic [1:0] PHASE_WAIT = 2'd2;

    typedef logic [1:0] phase_t;

endpackage

`default_nettype wire

>>> hw/rtl/clocked_panel_bus_transceiver.sv
// Each result word is registered in the output register, or in the skid stage.
// One word per cycle while s_tready is high; update and result are single-pass.
// A skid stage keeps s_tready high for one word while m_tready is low.
// aresetn is synchronous, active low: bus state clears, registers return to
// their defaults (gap 250, hold 52, sample 12), both output stages empty.
`default_nettype none

`include "clocked_panel_bus_transceiver_macros.svh"

module clocked_panel_bus_transceiver
    import cpbt_pkg::*;
#(
    parameter int WORD_BITS = WORD_BITS_DEF
) (
    input  wire logic                   aclk,
    input  wire logic                   aresetn,

    input  wire logic                   cfg_wr_en,
    input  wire logic [CFG_IDX_W-1:0]   cfg_index,
    input  wire logic [CFG_DATA_W-1:0]  cfg_wr_data,

    input  wire logic                   s_tvalid,
    output logic                        s_tready,
    // clock_level[0], data_level[1], send_word[65:2], send_valid[66], zero pad
    input  wire logic [S_TDATA_W-1:0]   s_tdata,

    output logic                        m_tvalid,
    input  wire logic                   m_tready,
    // drive_level[0], word_valid[1], word_bits[65:2], word_count[72:66],
    // send_taken[73], zero pad
    output logic [M_TDATA_W-1:0]        m_tdata
);

    localparam int IDX_W = $clog2(WORD_BITS);
    localparam int CNT_W = $clog2(WORD_BITS + 1);
    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(WORD_BITS - 1);
    localparam logic [CNT_W-1:0] CNT_MAX  = CNT_W'(WORD_BITS);

    // configuration
    logic [GAP_W-1:0]  gap_ticks_reg;
    logic [TICK_W-1:0] hold_ticks_reg;
    logic [TICK_W-1:0] sample_ticks_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            gap_ticks_reg    <= GAP_TICKS_RST;
            hold_ticks_reg   <= HOLD_TICKS_RST;
            sample_ticks_reg <= SAMPLE_TICKS_RST;
        end else if (cfg_wr_en) begin
            case (cfg_index)
                CFG_GAP_TICKS:    gap_ticks_reg    <= cfg_wr_data;
                CFG_HOLD_TICKS:   hold_ticks_reg   <= cfg_wr_data[TICK_W-1:0];
                CFG_SAMPLE_TICKS: sample_ticks_reg <= cfg_wr_data[TICK_W-1:0];
                default: ;
            endcase
        end
    end

    // input fields
    logic              in_clk;
    logic              in_data;
    logic [DATA_W-1:0] in_send_word;
    logic              in_send_valid;

    assign in_clk        = s_tdata[0];
    assign in_data       = s_tdata[1];
    assign in_send_word  = s_tdata[65:2];
    assign in_send_valid = s_tdata[66];

    // bus state
    logic                 clk_high_reg, clk_high_next;
    logic [GAP_W-1:0]     gap_cnt_reg, gap_cnt_next;
    phase_t               phase_reg, phase_next;
    logic [TICK_W-1:0]    cdown_reg, cdown_next;
    logic [WORD_BITS-1:0] rx_shift_reg, rx_shift_next;
    logic [IDX_W-1:0]     bit_idx_reg, bit_idx_next;
    logic [CNT_W-1:0]     smp_cnt_reg, smp_cnt_next;
    logic [WORD_BITS-1:0] tx_word_reg, tx_word_next;
    logic                 tx_known_reg, tx_known_next;

    logic                 res_drive;
    logic                 res_wvalid;
    logic [DATA_W-1:0]    res_wbits;
    logic [COUNT_W-1:0]   res_wcount;
    logic                 res_taken;
    logic [M_TDATA_W-1:0] res_word;

    logic [TICK_W-1:0]    cdown_dec;
    logic                 do_sample;
    logic                 drive_cur;

    assign cdown_dec = (cdown_reg == '0) ? '0 : cdown_reg - 1'b1;
    assign drive_cur = tx_known_reg && !tx_word_reg[LAST_IDX - bit_idx_reg];

    always_comb begin
        clk_high_next = clk_high_reg;
        gap_cnt_next  = (gap_cnt_reg == GAP_MAX) ? gap_cnt_reg : gap_cnt_reg + 1'b1;
        phase_next    = phase_reg;
        cdown_next    = cdown_reg;
        rx_shift_next = rx_shift_reg;
        bit_idx_next  = bit_idx_reg;
        smp_cnt_next  = smp_cnt_reg;
        tx_word_next  = tx_word_reg;
        tx_known_next = tx_known_reg;
        res_drive     = 1'b0;
        res_wvalid    = 1'b0;
        res_wbits     = '0;
        res_wcount    = '0;
        res_taken     = 1'b0;
        do_sample     = 1'b0;

        case (phase_reg)
            PHASE_HOLD: begin
                cdown_next = cdown_dec;
                if (cdown_dec != '0) begin
                    res_drive = drive_cur;
                end else begin
                    phase_next = PHASE_IDLE;
                end
            end
            PHASE_WAIT: begin
                cdown_next = cdown_dec;
                if (cdown_dec == '0) begin
                    do_sample  = 1'b1;
                    phase_next = PHASE_IDLE;
                end
            end
            default: begin
                phase_next = PHASE_IDLE;
                if (in_clk && !clk_high_reg) begin
                    if (gap_cnt_next > gap_ticks_reg) begin
                        res_wvalid = 1'b1;
                        res_wbits  = DATA_W'(rx_shift_reg) << (DATA_W - WORD_BITS);
                        res_wcount = COUNT_W'(smp_cnt_reg);
                        if (in_send_valid) begin
                            tx_word_next  = in_send_word[DATA_W-1 -: WORD_BITS];
                            tx_known_next = 1'b1;
                            res_taken     = 1'b1;
                        end
                        rx_shift_next = '0;
                        bit_idx_next  = '0;
                        smp_cnt_next  = '0;
                    end
                    gap_cnt_next  = '0;
                    clk_high_next = 1'b1;
                    if (hold_ticks_reg != '0) begin
                        res_drive  = tx_known_next &&
                                     !tx_word_next[LAST_IDX - bit_idx_next];
                        phase_next = PHASE_HOLD;
                        cdown_next = hold_ticks_reg;
                    end
                end else if (!in_clk && clk_high_reg) begin
                    clk_high_next = 1'b0;
                    if (sample_ticks_reg == '0) begin
                        do_sample = 1'b1;
                    end else begin
                        phase_next = PHASE_WAIT;
                        cdown_next = sample_ticks_reg;
                    end
                end
            end
        endcase

        if (do_sample) begin
            rx_shift_next[LAST_IDX - bit_idx_reg] = !in_data;
            if (smp_cnt_reg != CNT_MAX) begin
                smp_cnt_next = smp_cnt_reg + 1'b1;
            end
            if (bit_idx_reg < LAST_IDX) begin
                bit_idx_next = bit_idx_reg + 1'b1;
            end
        end
    end

    assign res_word = {6'b0, res_taken, res_wcount, res_wbits, res_wvalid, res_drive};

    logic s_accept;
    assign s_accept = s_tvalid && s_tready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            clk_high_reg <= 1'b0;
            gap_cnt_reg  <= '0;
            phase_reg    <= PHASE_IDLE;
            cdown_reg    <= '0;
            rx_shift_reg <= '0;
            bit_idx_reg  <= '0;
            smp_cnt_reg  <= '0;
            tx_word_reg  <= '0;
            tx_known_reg <= 1'b0;
        end else if (s_accept) begin
            clk_high_reg <= clk_high_next;
            gap_cnt_reg  <= gap_cnt_next;
            phase_reg    <= phase_next;
            cdown_reg    <= cdown_next;
            rx_shift_reg <= rx_shift_next;
            bit_idx_reg  <= bit_idx_next;
            smp_cnt_reg  <= smp_cnt_next;
            tx_word_reg  <= tx_word_next;
            tx_known_reg <= tx_known_next;
        end
    end

    // output register with skid stage
    logic                 out_valid_reg;
    logic [M_TDATA_W-1:0] out_data_reg;
    logic                 skid_valid_reg;
    logic [M_TDATA_W-1:0] skid_data_reg;

    assign s_tready = !skid_valid_reg;
    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end else if (s_accept) begin
            if (!out_valid_reg || m_tready) begin
                out_valid_reg <= 1'b1;
                out_data_reg  <= res_word;
            end else begin
                skid_valid_reg <= 1'b1;
                skid_data_reg  <= res_word;
            end
        end else if (out_valid_reg && m_tready) begin
            if (skid_valid_reg) begin
                out_data_reg   <= skid_data_reg;
                skid_valid_reg <= 1'b0;
            end else begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    `CPBT_ASSERT(a_skid_behind_out, aclk, aresetn, !skid_valid_reg || out_valid_reg, "skid full with output empty")
    `CPBT_ASSERT(a_idx_bound, aclk, aresetn, bit_idx_reg <= LAST_IDX, "bit index past last position")
    `CPBT_ASSERT(a_cnt_bound, aclk, aresetn, smp_cnt_reg <= CNT_MAX, "sample count past word size")
    `CPBT_NEVER(a_busy_cdown, aclk, aresetn, (phase_reg != PHASE_IDLE) && (cdown_reg == '0), "busy phase with zero countdown")

endmodule

`default_nettype wire
